>>> rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at each rising clock edge, disabled during reset.
`define ASSERT_IMP(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);
`endif

>>> rtl/cenc_pkg.sv
// ----------------------------------------------------------------------------
// CENC package
// Shared types, constants and AES helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cenc_pkg;

    localparam int BlkBytes = 16;
    localparam int OffW = 4;
    localparam int QDepth = 4;
    localparam int QPtrW = 2;

    localparam logic [2:0] RegKeyHigh = 3'd0;
    localparam logic [2:0] RegKeyLow = 3'd1;
    localparam logic [2:0] RegIvHigh = 3'd2;
    localparam logic [2:0] RegIvLow = 3'd3;
    localparam logic [2:0] RegStepMode = 3'd4;

    // One classified beat passed from the front to the back.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        protect;
        logic        new_block;
        logic [3:0]  offset;
        logic        last;
        logic [63:0] iv_high;
        logic [63:0] iv_low;
        logic [63:0] ctr_low;
    } cenc_op_t;

    typedef enum logic [1:0] {
        AES_IDLE,
        AES_RUN,
        AES_DONE
    } aes_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit word, byte 0 most significant.
    function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
        return w[127 - 8*i -: 8];
    endfunction

    // Next round key from the current one and the round constant.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows and, unless final, MixColumns.
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic final_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = sbox(byte_at(s, i + 4*((c + i) & 3)));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (final_rnd) begin
                o[127 - 32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[127 - 32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                       a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                       a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                       xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return o;
    endfunction

endpackage

>>> rtl/cenc_front.sv
// ----------------------------------------------------------------------------
// CENC front end
// Accepts beats, tracks byte offset, counter and IV, tags each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cenc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_protect,
    input  logic                in_last,
    input  logic                q_full,
    output logic                q_push,
    output cenc_pkg::cenc_op_t  q_op,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [63:0]         cfg_data,
    input  logic                step_mode
);
    import cenc_pkg::*;

    logic [63:0] iv_hi_reg, iv_hi_next, iv_lo_reg, iv_lo_next;
    logic [63:0] ctr_reg, ctr_next;
    logic [3:0]  off_reg, off_next;
    logic [31:0] cnt_reg, cnt_next;
    logic        nb;
    logic [31:0] cnt_now;
    logic [63:0] inc, lo_sum;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign nb       = in_protect && (off_reg == '0);
    assign cnt_now  = cnt_reg + {31'd0, nb};
    assign inc      = step_mode ? 64'd1 : {32'd0, cnt_now};
    assign lo_sum   = iv_lo_reg + inc;

    always_comb begin
        q_op = '{data_byte: in_byte, protect: in_protect, new_block: nb,
                 offset: off_reg, last: in_last, iv_high: iv_hi_reg,
                 iv_low: iv_lo_reg, ctr_low: ctr_reg};
    end

    always_comb begin
        iv_hi_next = iv_hi_reg;
        iv_lo_next = iv_lo_reg;
        ctr_next   = ctr_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        if (cfg_we && (cfg_idx == RegIvHigh || cfg_idx == RegIvLow)) begin
            if (cfg_idx == RegIvHigh) begin
                iv_hi_next = cfg_data;
                ctr_next = iv_lo_reg;
            end else begin
                iv_lo_next = cfg_data;
                ctr_next = cfg_data;
            end
            off_next = '0;
            cnt_next = '0;
        end else if (q_push) begin
            if (in_protect) begin
                off_next = off_reg + 4'd1;
            end
            if (nb) begin
                ctr_next = ctr_reg + 64'd1;
            end
            cnt_next = cnt_now;
            if (in_last) begin
                iv_lo_next = lo_sum;
                iv_hi_next = iv_hi_reg + {63'd0, (lo_sum < iv_lo_reg)};
                ctr_next   = lo_sum;
                off_next   = '0;
                cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iv_hi_reg <= '0;
            iv_lo_reg <= '0;
            ctr_reg   <= '0;
            off_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            iv_hi_reg <= iv_hi_next;
            iv_lo_reg <= iv_lo_next;
            ctr_reg   <= ctr_next;
            off_reg   <= off_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule

>>> rtl/cenc_queue.sv
// ----------------------------------------------------------------------------
// CENC beat queue
// Small FIFO of classified beats between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cenc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  cenc_pkg::cenc_op_t  push_op,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output cenc_pkg::cenc_op_t  head
);
    import cenc_pkg::*;

    cenc_op_t         mem_reg [QDepth];
    logic [QPtrW-1:0] wp_reg, rp_reg;
    logic [QPtrW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPtrW+1)'(QDepth));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    always_comb begin
        cnt_next = cnt_reg + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + QPtrW'(push);
            rp_reg  <= rp_reg + QPtrW'(pop);
            cnt_reg <= cnt_next;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMP(a_no_overflow, aclk, aresetn, full, !push, "queue push while full")
    `ASSERT_IMP(a_no_underflow, aclk, aresetn, empty, !pop, "queue pop while empty")
endmodule

>>> rtl/cenc_back.sv
// ----------------------------------------------------------------------------
// CENC back end
// Runs the iterative AES core when needed and XORs keystream bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cenc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  cenc_pkg::cenc_op_t  q_head,
    output logic                q_pop,
    input  logic [127:0]        key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic [63:0]         out_iv_high,
    output logic [63:0]         out_iv_low,
    output logic                out_last
);
    import cenc_pkg::*;

    aes_state_t   st_reg, st_next;
    logic [3:0]   rnd_reg;
    logic [127:0] s_reg, rk_reg, ks_reg;
    logic [7:0]   rc_reg;
    logic         ovalid_reg;
    logic [7:0]   obyte_reg;
    logic [63:0]  oivh_reg, oivl_reg;
    logic         olast_reg;
    logic         can_out, need_aes, go, aes_start;
    logic [127:0] nk;
    logic [7:0]   ksb;

    assign can_out   = !ovalid_reg || out_ready;
    assign need_aes  = q_head.new_block && (st_reg != AES_DONE);
    assign go        = !q_empty && can_out && !need_aes;
    assign q_pop     = go;
    assign aes_start = (st_reg == AES_IDLE) && !q_empty && q_head.new_block;
    assign nk        = key_step(rk_reg, rc_reg);
    assign ksb       = byte_at(ks_reg, int'(q_head.offset));

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            AES_IDLE: if (aes_start) st_next = AES_RUN;
            AES_RUN:  if (rnd_reg == 4'd10) st_next = AES_DONE;
            AES_DONE: if (go) st_next = AES_IDLE;
            default:  st_next = AES_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (aes_start) begin
            s_reg   <= {q_head.iv_high, q_head.ctr_low} ^ key;
            rk_reg  <= key;
            rc_reg  <= 8'h01;
            rnd_reg <= 4'd1;
        end else if (st_reg == AES_RUN) begin
            s_reg   <= round_fn(s_reg, rnd_reg == 4'd10) ^ nk;
            rk_reg  <= nk;
            rc_reg  <= xtime(rc_reg);
            rnd_reg <= rnd_reg + 4'd1;
            if (rnd_reg == 4'd10) begin
                ks_reg <= round_fn(s_reg, 1'b1) ^ nk;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            obyte_reg <= q_head.protect ? (q_head.data_byte ^ ksb) : q_head.data_byte;
            oivh_reg  <= q_head.last ? q_head.iv_high : 64'd0;
            oivl_reg  <= q_head.last ? q_head.iv_low : 64'd0;
            olast_reg <= q_head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= AES_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (go) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign out_iv_high = oivh_reg;
    assign out_iv_low  = oivl_reg;
    assign out_last    = olast_reg;

    `include "assert_macros.svh"
    `ASSERT_IMP(a_block_ready, aclk, aresetn, go && q_head.new_block, st_reg == AES_DONE,
        "new block consumed before keystream ready")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready, out_valid,
        "result dropped while stalled")
endmodule

>>> rtl/cenc_ctr_stream_encryptor.sv
// ----------------------------------------------------------------------------
// CENC AES-128-CTR stream encryptor
// Byte-wide sample encryptor with per-sample IV reporting and stepping.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata = data_byte[7:0]; tuser = {sample_end, protect}
// m_axis    out  tdata = out_byte, used_iv_high, used_iv_low; tlast
// apb       in   key, start IV and IV step mode registers at 8*i
//
// One beat per cycle for clear bytes and within a keystream block, while the
// output is not stalled. The first protected byte of each 16-byte block waits
// at the queue head for the iterative AES core (one load and ten rounds, one
// round per cycle). A four-entry queue decouples the input side from AES and
// output stalls. Reset is synchronous, active low, and clears IV, counter and
// all handshake state.
`timescale 1ns / 1ps
module cenc_ctr_stream_encryptor (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte
    input  logic [1:0]    s_tuser,   // protect, sample_end
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // out_byte, used_iv_high, used_iv_low
    output logic          m_tlast,   // last_of_sample
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import cenc_pkg::*;

    logic [63:0] key_hi_reg, key_lo_reg, siv_hi_reg, siv_lo_reg;
    logic        mode_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic        q_full, q_empty, q_push, q_pop;
    cenc_op_t    push_op, head;
    logic [7:0]  ob;
    logic [63:0] ivh, ivl;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            siv_hi_reg <= '0;
            siv_lo_reg <= '0;
            mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                RegKeyHigh:  key_hi_reg <= pwdata;
                RegKeyLow:   key_lo_reg <= pwdata;
                RegIvHigh:   siv_hi_reg <= pwdata;
                RegIvLow:    siv_lo_reg <= pwdata;
                RegStepMode: mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            RegKeyHigh:  prdata = key_hi_reg;
            RegKeyLow:   prdata = key_lo_reg;
            RegIvHigh:   prdata = siv_hi_reg;
            RegIvLow:    prdata = siv_lo_reg;
            RegStepMode: prdata = {63'd0, mode_reg};
            default:     prdata = '0;
        endcase
    end

    cenc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
        .in_protect(s_tuser[0]), .in_last(s_tuser[1]),
        .q_full(q_full), .q_push(q_push), .q_op(push_op),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(pwdata), .step_mode(mode_reg)
    );

    cenc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_op(push_op), .full(q_full),
        .pop(q_pop), .empty(q_empty), .head(head)
    );

    cenc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_head(head), .q_pop(q_pop),
        .key({key_hi_reg, key_lo_reg}),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_byte(ob), .out_iv_high(ivh), .out_iv_low(ivl), .out_last(m_tlast)
    );

    assign m_tdata = {ivl, ivh, ob};

    `include "assert_macros.svh"
    `ASSERT_IMP(a_cfg_idle, aclk, aresetn, cfg_we, !q_push,
        "configuration write while a beat is accepted")
endmodule
